>>> src/bfs_pkg.sv
// Shared types and constants for the bracket fold scanner.
`default_nettype none

package bfs_pkg;

    localparam int NUM_PAIRS = 4;
    localparam int MAX_PAIRS = 4;
    localparam int PAIR_CAP  = 31;
    localparam int PAIR_LIMIT_A = (MAX_PAIRS < PAIR_CAP) ? MAX_PAIRS : PAIR_CAP;
    localparam int PAIR_LIMIT = (PAIR_LIMIT_A < NUM_PAIRS) ? PAIR_LIMIT_A : NUM_PAIRS;

    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAIR_0     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAIR_1     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAIR_2     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAIR_3     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAIR_COUNT = 3'd4;

    localparam logic [15:0] PAIR_0_RESET     = 16'h2829;
    localparam logic [15:0] PAIR_1_RESET     = 16'h5B5D;
    localparam logic [15:0] PAIR_2_RESET     = 16'h7B7D;
    localparam logic [15:0] PAIR_3_RESET     = 16'h0000;
    localparam logic [2:0]  PAIR_COUNT_RESET = 3'd3;

    localparam logic REQ_TEXT  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef logic [NUM_PAIRS-1:0][15:0] pair_array_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_byte;
        logic       suppressed;
        logic [15:0] line_number;
    } req_data_t;

    typedef struct packed {
        logic        fold_valid;
        logic [15:0] start_line;
        logic [15:0] end_line;
        logic        push_dropped;
        logic [6:0]  stack_depth;
    } rsp_data_t;

    typedef struct packed {
        logic       opener;
        logic       closer;
        logic [7:0] close_chr;
    } pair_class_t;

endpackage

`default_nettype wire

>>> src/bfs_pair_match.sv
// Bracket pair lookup: classify a byte as opener or closer of the first enabled pair that holds it.
`default_nettype none

module bfs_pair_match
    import bfs_pkg::*;
(
    input  wire pair_array_t pairs,
    input  wire logic [2:0]  pair_count,
    input  wire logic [7:0]  char_byte,
    output pair_class_t      pair_class
);

    logic [2:0] count_eff;
    logic       found;
    logic [7:0] open_b;
    logic [7:0] close_b;

    always_comb
    begin
        count_eff = (pair_count > 3'(PAIR_LIMIT)) ? 3'(PAIR_LIMIT) : pair_count;
        found     = 1'b0;
        open_b    = 8'h00;
        close_b   = 8'h00;
        for (int i = 0; i < NUM_PAIRS; i++)
        begin
            if (!found && (3'(i) < count_eff) &&
                ((pairs[i][15:8] == char_byte) || (pairs[i][7:0] == char_byte)))
            begin
                found   = 1'b1;
                open_b  = pairs[i][15:8];
                close_b = pairs[i][7:0];
            end
        end
        pair_class.opener    = found && (open_b != close_b) && (char_byte == open_b);
        pair_class.closer    = found && (open_b != close_b) && (char_byte != open_b);
        pair_class.close_chr = close_b;
    end

endmodule

`default_nettype wire

>>> src/bracket_fold_scanner_top.sv
// Top level of the bracket fold scanner: request register, bracket stack, result register.
//
// Usage:
//   Requests enter on req_valid / req_stall / req_data, one text byte (or a clear
//   command) per request. Results leave on rsp_valid / rsp_stall / rsp_data, exactly
//   one result per request, in order.
//   A request waits in the request register; its result goes to the result register,
//   which drives rsp_data. Throughput: one request per cycle while no result is stalled;
//   the top of the stack lives in a register and the entry below it is prefetched from
//   the stack memory, so a push or pop never holds up the next request.
//   A stalled result holds rsp_data; req_stall is high while the request register
//   is full behind a stalled result, so at most one request waits behind it.
//   Reset empties the stack, restores the bracket pairs to (), [] and {} with three
//   pairs enabled, and leaves both channels empty. No clearing pass is needed.
//   Configuration goes through cfg_wr_en / cfg_index / cfg_data; the user must write it
//   only while no request is in flight, as the block itself does not enforce this.
`default_nettype none

module bracket_fold_scanner_top
    import bfs_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int LINE_BITS   = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_stall,
    input  wire req_data_t              req_data,
    output logic                        rsp_valid,
    input  wire logic                   rsp_stall,
    output rsp_data_t                   rsp_data,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0]            cfg_data
);

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = $clog2(STACK_DEPTH);

    typedef struct packed {
        logic [7:0]           close_chr;
        logic [LINE_BITS-1:0] line;
    } entry_t;

    pair_array_t pairs_reg;
    logic [2:0]  pair_count_reg;

    logic      req_vld_reg, req_vld_next;
    req_data_t req_data_reg;
    logic      rsp_vld_reg, rsp_vld_next;
    rsp_data_t rsp_data_reg, rsp_data_next;

    logic [DEPTH_W-1:0] depth_reg, depth_next;
    entry_t             top_reg, top_next;
    entry_t             below_reg;
    entry_t             mem [STACK_DEPTH-1];

    logic               advance;
    pair_class_t        pair_class;
    logic [LINE_BITS-1:0] line_in;
    logic [DEPTH_W-1:0] depth_m1;
    logic [DEPTH_W-1:0] depth_m2;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_wr;
    logic               rd_en;

    bfs_pair_match u_pair_match (
        .pairs      (pairs_reg),
        .pair_count (pair_count_reg),
        .char_byte  (req_data_reg.char_byte),
        .pair_class (pair_class)
    );

    assign advance   = req_vld_reg && (!rsp_vld_reg || !rsp_stall);
    assign req_stall = req_vld_reg && !advance;
    assign rsp_valid = rsp_vld_reg;
    assign rsp_data  = rsp_data_reg;

    always_comb
    begin
        line_in  = LINE_BITS'(req_data_reg.line_number);
        depth_m1 = depth_reg - DEPTH_W'(1);
        wr_addr  = depth_m1[ADDR_W-1:0];

        depth_next    = depth_reg;
        top_next      = top_reg;
        mem_wr        = 1'b0;
        rsp_data_next = '0;

        if (advance)
        begin
            if (req_data_reg.req_type == REQ_CLEAR)
            begin
                depth_next = '0;
            end
            else if (!req_data_reg.suppressed)
            begin
                if (pair_class.opener)
                begin
                    if (depth_reg < DEPTH_W'(STACK_DEPTH))
                    begin
                        mem_wr             = (depth_reg != '0);
                        top_next.close_chr = pair_class.close_chr;
                        top_next.line      = line_in;
                        depth_next         = depth_reg + DEPTH_W'(1);
                    end
                    else
                    begin
                        rsp_data_next.push_dropped = 1'b1;
                    end
                end
                else if (pair_class.closer && (depth_reg != '0) &&
                         (top_reg.close_chr == req_data_reg.char_byte))
                begin
                    top_next   = below_reg;
                    depth_next = depth_m1;
                    if (line_in > top_reg.line)
                    begin
                        rsp_data_next.fold_valid = 1'b1;
                        rsp_data_next.start_line = 16'(top_reg.line);
                        rsp_data_next.end_line   = 16'(line_in);
                    end
                end
            end
        end
        rsp_data_next.stack_depth = 7'(depth_next);

        depth_m2 = depth_next - DEPTH_W'(2);
        rd_addr  = depth_m2[ADDR_W-1:0];
        rd_en    = (depth_next >= DEPTH_W'(2));
    end

    always_comb
    begin
        if (!req_stall)
        begin
            req_vld_next = req_valid;
        end
        else
        begin
            req_vld_next = req_vld_reg;
        end

        if (advance)
        begin
            rsp_vld_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_vld_next = 1'b0;
        end
        else
        begin
            rsp_vld_next = rsp_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg    <= 1'b0;
            rsp_vld_reg    <= 1'b0;
            depth_reg      <= '0;
            pairs_reg[0]   <= PAIR_0_RESET;
            pairs_reg[1]   <= PAIR_1_RESET;
            pairs_reg[2]   <= PAIR_2_RESET;
            pairs_reg[3]   <= PAIR_3_RESET;
            pair_count_reg <= PAIR_COUNT_RESET;
        end
        else
        begin
            req_vld_reg <= req_vld_next;
            rsp_vld_reg <= rsp_vld_next;
            depth_reg   <= depth_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_PAIR_0:     pairs_reg[0]   <= cfg_data;
                    CFG_PAIR_1:     pairs_reg[1]   <= cfg_data;
                    CFG_PAIR_2:     pairs_reg[2]   <= cfg_data;
                    CFG_PAIR_3:     pairs_reg[3]   <= cfg_data;
                    CFG_PAIR_COUNT: pair_count_reg <= cfg_data[2:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_data_reg <= req_data;
        end
        if (advance)
        begin
            rsp_data_reg <= rsp_data_next;
        end
        top_reg <= top_next;
    end

    // Stack memory below the top entry; prefetch the entry under the next top.
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[wr_addr] <= top_reg;
        end
        if (rd_en)
        begin
            if (mem_wr && (wr_addr == rd_addr))
            begin
                below_reg <= top_reg;
            end
            else
            begin
                below_reg <= mem[rd_addr];
            end
        end
    end

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_depth_report: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_vld_reg |-> (rsp_data_reg.stack_depth == 7'(depth_reg)))
        else $error("reported depth differs from stack");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_vld_reg && rsp_data_reg.push_dropped) |-> (depth_reg == DEPTH_W'(STACK_DEPTH)))
        else $error("push dropped while stack not full");

    a_fold_order: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_vld_reg && rsp_data_reg.fold_valid) |->
            (rsp_data_reg.end_line > rsp_data_reg.start_line))
        else $error("fold closer not after opener");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_vld_reg && rsp_stall))
        else $error("request stalled without a stalled result");

endmodule

`default_nettype wire
